FILE: hdl/vbd_pkg.sv
package vbd_pkg;

    // request modes
    localparam logic [2:0] MODE_WRITE    = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_BOOL     = 3'd2;
    localparam logic [2:0] MODE_LITERAL  = 3'd3;
    localparam logic [2:0] MODE_SIGNED   = 3'd4;
    localparam logic [2:0] MODE_OPTIONAL = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // coder constants
    localparam logic [7:0]        HALF_PROB   = 8'd128;
    localparam logic [7:0]        FULL_RANGE  = 8'd255;
    localparam logic signed [5:0] START_BITS  = -6'sd8;
    localparam logic signed [6:0] FILL_LIMIT  = 7'sd16;
    localparam logic signed [6:0] MIN_BITS    = -7'sd32;
    localparam logic [4:0]        MAX_LITERAL = 5'd24;

    // coder state after one bool, before any refill
    typedef struct packed {
        logic [7:0]        range;
        logic [31:0]       code;
        logic signed [5:0] bits;
        logic              bit_out;
        logic              need_fill;
    } t_step;

endpackage

FILE: hdl/vp8_bool_decoder.sv
// VP8 boolean entropy decoder over an internal byte store of BUFFER_BYTES
// bytes. Write requests fill the store one byte each; a start request resets
// the coder and prefills it from the first partition_length bytes. Each
// request returns exactly one result. Each bool of a literal goes through
// split multiply, range update, bit merge and sequencing; a refill reads
// the store a byte at a time, waiting on its registered read port.
// Requests are handled one at a time; a finished result waits in the output
// register while the next request is taken. The configuration register is
// always ready and should be written only while the block is idle.
module vp8_bool_decoder import vbd_pkg::*; #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [12:0]        i_cfg_partition_length,
    // requests
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_mode,
    input  logic [11:0]        i_address,
    input  logic [7:0]         i_byte_data,
    input  logic [7:0]         i_probability,
    input  logic [4:0]         i_bit_count,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [24:0] o_value,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(BUFFER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_SPLIT, S_UPDATE, S_FILL, S_FILL_WAIT, S_BIT, S_NEXT, S_DONE
    } t_state;

    typedef enum logic [1:0] {PH_BOOL, PH_FLAG, PH_MAG, PH_SIGN} t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [2:0]        r_mode, n_mode;
    logic [7:0]        r_prob, n_prob;
    logic [4:0]        r_n, n_n;
    logic [4:0]        r_cnt, n_cnt;
    logic [23:0]       r_acc, n_acc;
    logic              r_bit, n_bit;
    logic [7:0]        r_split, n_split;
    logic              r_start, n_start;
    logic [12:0]       r_pos, n_pos;
    logic [31:0]       r_code, n_code;
    logic [7:0]        r_range, n_range;
    logic signed [5:0] r_bits, n_bits;
    logic [12:0]       r_plen, n_plen;
    logic signed [24:0] r_res_value, n_res_value;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic signed [24:0] r_out_value, n_out_value;
    logic [1:0]        r_out_status, n_out_status;

    logic              in_req;
    logic              wr_en;
    logic [7:0]        rd_data;
    logic [12:0]       limit;
    logic              can_fill;
    logic signed [6:0] fill_sh;
    logic [31:0]       fill_bits;
    logic [7:0]        use_prob;
    logic [15:0]       prod;
    logic [4:0]        n_clamp;
    logic signed [24:0] mag;
    t_step             step;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_req      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

    // byte store
    assign wr_en = in_req && (i_mode == MODE_WRITE)
                   && (32'(i_address) < 32'(BUFFER_BYTES));

    vbd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_address)),
        .i_wdata (i_byte_data),
        .i_raddr (AW'(r_pos)),
        .o_rdata (rd_data)
    );

    // refill condition and byte placement
    assign limit     = (32'(r_plen) < 32'(BUFFER_BYTES)) ? r_plen : 13'(BUFFER_BYTES);
    assign can_fill  = ($signed({r_bits[5], r_bits}) <= FILL_LIMIT) && (r_pos < limit);
    assign fill_sh   = FILL_LIMIT - {r_bits[5], r_bits};
    assign fill_bits = (fill_sh[6:5] == 2'b00) ? (32'(rd_data) << fill_sh[4:0]) : 32'd0;

    // split point multiply
    assign use_prob = (r_phase == PH_BOOL) ? r_prob : HALF_PROB;
    assign prod     = (r_range - 8'd1) * use_prob;

    assign n_clamp = (i_bit_count > MAX_LITERAL) ? MAX_LITERAL : i_bit_count;
    assign mag     = {1'b0, r_acc};

    // one bool decision and renormalization
    vbd_step u_step (
        .i_range (r_range),
        .i_code  (r_code),
        .i_bits  (r_bits),
        .i_split (r_split),
        .o_step  (step)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_mode       = r_mode;
        n_prob       = r_prob;
        n_n          = r_n;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_bit        = r_bit;
        n_split      = r_split;
        n_start      = r_start;
        n_pos        = r_pos;
        n_code       = r_code;
        n_range      = r_range;
        n_bits       = r_bits;
        n_plen       = i_cfg_valid ? i_cfg_partition_length : r_plen;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        case (r_state)
            S_IDLE: begin
                if (in_req) begin
                    n_mode       = i_mode;
                    n_prob       = i_probability;
                    n_n          = n_clamp;
                    n_cnt        = n_clamp;
                    n_acc        = '0;
                    n_res_value  = '0;
                    n_res_status = ST_OK;
                    case (i_mode)
                        MODE_START: begin
                            n_pos   = '0;
                            n_code  = '0;
                            n_range = FULL_RANGE;
                            n_bits  = START_BITS;
                            n_start = 1'b1;
                            n_state = S_FILL;
                        end
                        MODE_BOOL: begin
                            n_phase = PH_BOOL;
                            n_state = S_SPLIT;
                        end
                        MODE_LITERAL, MODE_SIGNED: begin
                            n_phase = PH_MAG;
                            n_state = S_NEXT;
                        end
                        MODE_OPTIONAL: begin
                            n_phase = PH_FLAG;
                            n_state = S_SPLIT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SPLIT: begin
                if (r_range == 8'd0) begin
                    n_res_value  = '0;
                    n_res_status = ST_ZERO;
                    n_state      = S_DONE;
                end else begin
                    n_split = prod[15:8] + 8'd1;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_range = step.range;
                n_code  = step.code;
                n_bits  = step.bits;
                n_bit   = step.bit_out;
                n_start = 1'b0;
                n_state = step.need_fill ? S_FILL : S_BIT;
            end
            S_FILL: begin
                if (can_fill) begin
                    n_state = S_FILL_WAIT;
                end else if (r_start) begin
                    n_state = S_DONE;
                end else if (r_bits < 6'sd0) begin
                    n_res_value  = '0;
                    n_res_status = ST_TRUNC;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_BIT;
                end
            end
            S_FILL_WAIT: begin
                n_code  = r_code | fill_bits;
                n_pos   = r_pos + 13'd1;
                n_bits  = r_bits + 6'sd8;
                n_state = S_FILL;
            end
            S_BIT: begin
                case (r_phase)
                    PH_BOOL: begin
                        n_res_value = 25'(r_bit);
                        n_state     = S_DONE;
                    end
                    PH_FLAG: begin
                        if (r_bit) begin
                            n_phase = PH_MAG;
                            n_cnt   = r_n;
                            n_acc   = '0;
                            n_state = S_NEXT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    PH_MAG: begin
                        n_acc   = {r_acc[22:0], r_bit};
                        n_cnt   = r_cnt - 5'd1;
                        n_state = S_NEXT;
                    end
                    default: begin
                        n_res_value = r_bit ? -mag : mag;
                        n_state     = S_DONE;
                    end
                endcase
            end
            S_NEXT: begin
                if (r_cnt != 5'd0) begin
                    n_state = S_SPLIT;
                end else if (r_mode == MODE_LITERAL) begin
                    n_res_value = mag;
                    n_state     = S_DONE;
                end else if (r_acc == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_phase = PH_SIGN;
                    n_state = S_SPLIT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_pos       <= '0;
            r_code      <= '0;
            r_range     <= FULL_RANGE;
            r_bits      <= START_BITS;
            r_plen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_pos       <= n_pos;
            r_code      <= n_code;
            r_range     <= n_range;
            r_bits      <= n_bits;
            r_plen      <= n_plen;
            r_out_valid <= n_out_valid;
        end
        r_phase      <= n_phase;
        r_mode       <= n_mode;
        r_prob       <= n_prob;
        r_n          <= n_n;
        r_cnt        <= n_cnt;
        r_acc        <= n_acc;
        r_bit        <= n_bit;
        r_split      <= n_split;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

FILE: hdl/vbd_ram.sv
module vbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/vbd_step.sv
module vbd_step import vbd_pkg::*; (
    input  logic [7:0]        i_range,
    input  logic [31:0]       i_code,
    input  logic signed [5:0] i_bits,
    input  logic [7:0]        i_split,
    output t_step             o_step
);

    logic [31:0]       big;
    logic              take_high;
    logic [7:0]        rng;
    logic [31:0]       code;
    logic [2:0]        sh;
    logic signed [6:0] bits_dec;

    // compare against the split point
    assign big       = {i_split, 24'd0};
    assign take_high = (i_code >= big);
    assign rng       = take_high ? (i_range - i_split) : i_split;
    assign code      = take_high ? (i_code - big) : i_code;

    // leading zero count brings the range back to 128 or more
    always_comb begin
        sh = 3'd0;
        for (int k = 7; k >= 1; k--) begin
            if ((rng >> k) == 8'd0) begin
                sh = 3'(8 - k);
            end
        end
    end

    // shift out consumed bits, saturate the bit count
    assign bits_dec = {i_bits[5], i_bits} - {4'd0, sh};

    always_comb begin
        o_step.range     = 8'(rng << sh);
        o_step.code      = code << sh;
        o_step.bits      = (bits_dec < MIN_BITS) ? 6'(MIN_BITS) : 6'(bits_dec);
        o_step.bit_out   = take_high;
        o_step.need_fill = (bits_dec < 7'sd0);
    end

endmodule

FILE: sim/vbd_checker.sv
module vbd_checker import vbd_pkg::*; #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [12:0]        i_cfg_partition_length,
    // requests
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_mode,
    input  logic [11:0]        i_address,
    input  logic [7:0]         i_byte_data,
    input  logic [7:0]         i_probability,
    input  logic [4:0]         i_bit_count,
    // results
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [24:0] i_value,
    input  logic [1:0]         i_status,
    // verdict inputs for the top
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FULL_SPAN      = 255;
    localparam int unsigned HALF_SPAN      = 128;
    localparam int          HELD_AT_START  = -8;
    localparam int          REFILL_CEILING = 16;
    localparam int          HELD_FLOOR     = -32;
    localparam int unsigned WIDEST_LITERAL = 24;

    typedef struct {
        logic signed [24:0] value;
        logic [1:0]         status;
    } t_outcome;

    // shadow copy of the decoder
    logic [7:0]  byte_mem [BUFFER_BYTES];
    int unsigned part_len;
    int unsigned read_pos;
    logic [31:0] code;
    int unsigned span;
    int          held_bits;

    t_outcome    expected_q [$];
    int          fails = 0;

    assign o_fail_count = fails;

    // pull partition bytes into the code value
    function automatic void refill_code();
        int unsigned limit;
        int          sh;
        limit = (part_len < BUFFER_BYTES) ? part_len : BUFFER_BYTES;
        while (held_bits <= REFILL_CEILING && read_pos < limit) begin
            sh = REFILL_CEILING - held_bits;
            if (sh < 32) begin
                code = code | (32'(byte_mem[read_pos]) << sh);
            end
            read_pos++;
            held_bits += 8;
        end
    endfunction

    // one bool at the given probability of zero
    function automatic logic [1:0] decode_bool_at(input int unsigned prob,
                                                  output logic bit_out);
        int unsigned split;
        logic [31:0] big;
        logic        decided;
        int          shift;
        bit_out = 1'b0;
        shift   = 0;
        if (span == 0) begin
            return ST_ZERO;
        end
        split = 1 + (((span - 1) * prob) >> 8);
        big   = 32'(split) << 24;
        if (code >= big) begin
            span    = span - split;
            code    = code - big;
            decided = 1'b1;
        end else begin
            span    = split;
            decided = 1'b0;
        end
        // renormalize
        while (span != 0 && span < HALF_SPAN) begin
            span = span << 1;
            shift++;
        end
        span      = span & FULL_SPAN;
        code      = code << shift;
        held_bits = held_bits - shift;
        if (held_bits < HELD_FLOOR) begin
            held_bits = HELD_FLOOR;
        end
        if (held_bits < 0) begin
            refill_code();
            if (held_bits < 0) begin
                return ST_TRUNC;
            end
        end
        bit_out = decided;
        return ST_OK;
    endfunction

    // unsigned literal, msb first
    function automatic logic [1:0] decode_literal_of(input int unsigned n,
                                                     output logic [23:0] mag);
        logic [23:0] acc;
        logic        b;
        logic [1:0]  st;
        acc = '0;
        mag = '0;
        for (int unsigned i = 0; i < n; i++) begin
            st = decode_bool_at(HALF_SPAN, b);
            if (st != ST_OK) begin
                return st;
            end
            acc = {acc[22:0], b};
        end
        mag = acc;
        return ST_OK;
    endfunction

    // magnitude, then a sign bit when nonzero
    function automatic logic [1:0] decode_signed_of(input int unsigned n,
                                                    output logic [24:0] v);
        logic [23:0] mag;
        logic        sign_bit;
        logic [1:0]  st;
        v  = '0;
        st = decode_literal_of(n, mag);
        if (st != ST_OK) begin
            return st;
        end
        if (mag == 0) begin
            return ST_OK;
        end
        st = decode_bool_at(HALF_SPAN, sign_bit);
        if (st != ST_OK) begin
            return st;
        end
        v = sign_bit ? (25'd0 - {1'b0, mag}) : {1'b0, mag};
        return ST_OK;
    endfunction

    // expected result of one request
    function automatic t_outcome predict_request(input logic [2:0] mode,
                                                 input logic [11:0] addr,
                                                 input logic [7:0] data,
                                                 input logic [7:0] prob,
                                                 input logic [4:0] cnt);
        t_outcome    res;
        int unsigned n;
        logic [24:0] v;
        logic [23:0] mag;
        logic        flag;
        logic [1:0]  st;
        n    = (cnt > WIDEST_LITERAL) ? WIDEST_LITERAL : cnt;
        v    = '0;
        mag  = '0;
        flag = 1'b0;
        st   = ST_OK;
        case (mode)
            MODE_WRITE: begin
                if (addr < BUFFER_BYTES) begin
                    byte_mem[addr] = data;
                end
            end
            MODE_START: begin
                read_pos  = 0;
                code      = '0;
                span      = FULL_SPAN;
                held_bits = HELD_AT_START;
                refill_code();
            end
            MODE_BOOL: begin
                st = decode_bool_at(prob, flag);
                v  = {24'd0, flag};
            end
            MODE_LITERAL: begin
                st = decode_literal_of(n, mag);
                v  = {1'b0, mag};
            end
            MODE_SIGNED: begin
                st = decode_signed_of(n, v);
            end
            MODE_OPTIONAL: begin
                st = decode_bool_at(HALF_SPAN, flag);
                if (st == ST_OK && flag) begin
                    st = decode_signed_of(n, v);
                end
            end
            default: begin
            end
        endcase
        if (st != ST_OK) begin
            v = '0;
        end
        res.value  = v;
        res.status = st;
        return res;
    endfunction

    // watch the channels: config, results, then new requests
    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            part_len  = 0;
            read_pos  = 0;
            code      = '0;
            span      = FULL_SPAN;
            held_bits = HELD_AT_START;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                part_len = i_cfg_partition_length;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result without a pending request: value %0d status %0d",
                           i_value, i_status);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, i_value);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(predict_request(i_mode, i_address, i_byte_data,
                                                     i_probability, i_bit_count));
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

FILE: sim/tb_vp8_bool_decoder.sv
module tb_vp8_bool_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import vbd_pkg::*;

    localparam int          BUFFER_BYTES   = 4096;
    localparam logic [2:0]  MODE_SPARE_LO  = 3'd6;
    localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;
    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 6;
    localparam int          MAX_IDLE       = 12;
    localparam int          LONG_HOLD      = 300;
    localparam int          HOLD_AT_RESULT = 150;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          RANDOM_PHASES  = 6;
    localparam int          REQS_PER_PHASE = 35;
    localparam int          MAX_PHASE_LEN  = 120;
    localparam int          DRAIN_REQS     = 30;
    localparam int unsigned DRAIN_LEN      = 64;
    localparam longint      RUN_LIMIT_NS   = 60_000_000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [12:0]        cfg_len;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_mode;
    logic [11:0]        req_addr;
    logic [7:0]         req_data;
    logic [7:0]         req_prob;
    logic [4:0]         req_count;
    logic               out_valid;
    logic               out_ready;
    logic signed [24:0] out_value;
    logic [1:0]         out_status;

    int fail_count;
    int pending;
    int results_taken;
    bit idle_on;
    bit written [BUFFER_BYTES];

    vp8_bool_decoder #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) DUT (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_valid            (cfg_valid),
        .o_cfg_ready            (cfg_ready),
        .i_cfg_partition_length (cfg_len),
        .i_in_valid             (in_valid),
        .o_in_ready             (in_ready),
        .i_mode                 (req_mode),
        .i_address              (req_addr),
        .i_byte_data            (req_data),
        .i_probability          (req_prob),
        .i_bit_count            (req_count),
        .o_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .o_value                (out_value),
        .o_status               (out_status)
    );

    vbd_checker #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_checker (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_valid            (cfg_valid),
        .i_cfg_ready            (cfg_ready),
        .i_cfg_partition_length (cfg_len),
        .i_in_valid             (in_valid),
        .i_in_ready             (in_ready),
        .i_mode                 (req_mode),
        .i_address              (req_addr),
        .i_byte_data            (req_data),
        .i_probability          (req_prob),
        .i_bit_count            (req_count),
        .i_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .i_value                (out_value),
        .i_status               (out_status),
        .o_fail_count           (fail_count),
        .o_pending              (pending)
    );

    // clock
    initial begin : clock_gen
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // run limit
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one request after a random gap, hold it until taken
    task automatic send_request(input logic [2:0] mode, input logic [11:0] addr,
                                input logic [7:0] data, input logic [7:0] prob,
                                input logic [4:0] cnt);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_mode  <= mode;
        req_addr  <= addr;
        req_data  <= data;
        req_prob  <= prob;
        req_count <= cnt;
        if (mode == MODE_WRITE) begin
            written[addr] = 1'b1;
        end
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_byte(input logic [11:0] addr, input logic [7:0] data);
        send_request(MODE_WRITE, addr, data, 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)));
    endtask

    // request with random content in the unused fields
    task automatic send_decode(input logic [2:0] mode, input logic [7:0] prob,
                               input logic [4:0] cnt);
        send_request(mode, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                     prob, cnt);
    endtask

    // write every partition byte not yet in the store
    task automatic fill_partition(input int unsigned len);
        int unsigned limit;
        limit = (len < BUFFER_BYTES) ? len : BUFFER_BYTES;
        for (int unsigned i = 0; i < limit; i++) begin
            if (!written[i]) begin
                write_byte(12'(i), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // stop offering and wait for every result
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_partition(input int unsigned len);
        settle();
        cfg_valid <= 1'b1;
        cfg_len   <= 13'(len);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one random request, mostly decodes
    task automatic random_request();
        int         pick;
        logic [4:0] cnt;
        logic [7:0] prob;
        pick = $urandom_range(0, 99);
        cnt  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(25, 31))
                                            : 5'($urandom_range(0, 24));
        prob = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                            : 8'($urandom_range(0, 255));
        if (pick < 6) begin
            write_byte(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
        end else if (pick < 10) begin
            send_decode(MODE_START, prob, cnt);
        end else if (pick < 13) begin
            send_decode($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO, prob, cnt);
        end else if (pick < 35) begin
            send_decode(MODE_BOOL, prob, cnt);
        end else if (pick < 60) begin
            send_decode(MODE_LITERAL, prob, cnt);
        end else if (pick < 80) begin
            send_decode(MODE_SIGNED, prob, cnt);
        end else begin
            send_decode(MODE_OPTIONAL, prob, cnt);
        end
    endtask

    // result side: random stalls, one long hold-off to back up the block
    initial begin : result_sink
        int gap;
        out_ready <= 1'b0;
        results_taken = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (results_taken == HOLD_AT_RESULT) begin
                gap = LONG_HOLD;
            end else begin
                gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    // request stimulus
    initial begin : stimulus
        int unsigned len;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_len   <= '0;
        in_valid  <= 1'b0;
        req_mode  <= MODE_WRITE;
        req_addr  <= '0;
        req_data  <= '0;
        req_prob  <= '0;
        req_count <= '0;
        idle_on = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty partition: decodes truncate, zero-width literals do not
        set_partition(0);
        send_decode(MODE_BOOL, 8'd128, 5'd1);
        send_decode(MODE_START, 8'd0, 5'd0);
        send_decode(MODE_LITERAL, 8'd0, 5'd0);
        send_decode(MODE_SIGNED, 8'd255, 5'd0);
        send_decode(MODE_OPTIONAL, 8'd128, 5'd5);
        send_decode(MODE_SPARE_LO, 8'd255, 5'd31);
        send_decode(MODE_SPARE_HI, 8'd0, 5'd24);

        // short partition with extreme bytes, run until it truncates
        write_byte(12'd0, 8'hFF);
        write_byte(12'd1, 8'h00);
        write_byte(12'd2, 8'hA5);
        write_byte(12'd3, 8'h5A);
        write_byte(12'd4, 8'hFF);
        write_byte(12'd5, 8'h80);
        write_byte(12'hFFF, 8'hFF);
        set_partition(6);
        send_decode(MODE_START, 8'd128, 5'd0);
        send_decode(MODE_BOOL, 8'd0, 5'd0);
        send_decode(MODE_BOOL, 8'd255, 5'd0);
        send_decode(MODE_LITERAL, 8'd128, 5'd24);
        send_decode(MODE_LITERAL, 8'd128, 5'd31);
        send_decode(MODE_SIGNED, 8'd128, 5'd7);
        send_decode(MODE_OPTIONAL, 8'd128, 5'd3);
        send_decode(MODE_BOOL, 8'd1, 5'd0);
        send_decode(MODE_LITERAL, 8'd128, 5'd24);

        // random phases over short partitions
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_on = (ph != 3);
            len = $urandom_range(1, MAX_PHASE_LEN);
            fill_partition(len);
            set_partition(len);
            send_decode(MODE_START, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            repeat (REQS_PER_PHASE) random_request();
        end

        // one partition read to its end with back-to-back literals
        idle_on = 1'b0;
        fill_partition(DRAIN_LEN);
        set_partition(DRAIN_LEN);
        send_decode(MODE_START, 8'd0, 5'd0);
        repeat (DRAIN_REQS) send_decode(MODE_LITERAL, 8'($urandom_range(0, 255)), 5'd24);
        idle_on = 1'b1;
        repeat (10) random_request();

        settle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/vbd_pkg.sv
hdl/vbd_ram.sv
hdl/vbd_step.sv
hdl/vp8_bool_decoder.sv
sim/vbd_checker.sv
sim/tb_vp8_bool_decoder.sv
